// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rotation core checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define AR3D_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ar3d: assertion failed");

// Checked at every clock edge, reset included.
`define AR3D_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ar3d: assertion failed");

`endif

// ----- src/ar3d_pkg.sv -----
// ----------------------------------------------------------------------------
// ar3d_pkg
// Constants, codes and the arctangent table of the 3D axis rotation core.
// ----------------------------------------------------------------------------
package ar3d_pkg;

   localparam int DEF_COORD_WIDTH     = 32;
   localparam int DEF_ROTATION_STAGES = 24;
   localparam int ATAN_ENTRIES        = 40;
   localparam int GUARD_BITS          = 8;
   localparam int ANGLE_WIDTH         = 32;
   localparam int AXIS_WIDTH          = 2;
   // Residual angle width: the folded angle lies within a quarter turn either side
   // of zero, and the micro-rotations never move it far beyond that.
   localparam int Z_WIDTH             = 34;
   localparam int GAIN_SHIFT          = 31;
   localparam logic [GAIN_SHIFT-1:0] GAIN_Q31 = 31'd1304065748;

   localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [ANGLE_WIDTH-1:0] HALF_TURN    = 32'h8000_0000;

   typedef logic [AXIS_WIDTH-1:0] axis_type;

   localparam axis_type AXIS_X    = 2'd0;
   localparam axis_type AXIS_Y    = 2'd1;
   localparam axis_type AXIS_Z    = 2'd2;
   localparam axis_type AXIS_NONE = 2'd3;

   // Entry i is floor(atan(2^-i) * 2^32 / (2 pi)); entries from 30 on are zero.
   function automatic logic [ANGLE_WIDTH-1:0] atan_turns(input int idx);
      logic [ANGLE_WIDTH-1:0] val;
      case (idx)
         0:       val = 32'h2000_0000;
         1:       val = 32'h12E4_051D;
         2:       val = 32'h09FB_385B;
         3:       val = 32'h0511_11D4;
         4:       val = 32'h028B_0D43;
         5:       val = 32'h0145_D7E1;
         6:       val = 32'h00A2_F61E;
         7:       val = 32'h0051_7C55;
         8:       val = 32'h0028_BE53;
         9:       val = 32'h0014_5F2F;
         10:      val = 32'h000A_2F98;
         11:      val = 32'h0005_17CC;
         12:      val = 32'h0002_8BE6;
         13:      val = 32'h0001_45F3;
         14:      val = 32'h0000_A2F9;
         15:      val = 32'h0000_517C;
         16:      val = 32'h0000_28BE;
         17:      val = 32'h0000_145F;
         18:      val = 32'h0000_0A2F;
         19:      val = 32'h0000_0517;
         20:      val = 32'h0000_028B;
         21:      val = 32'h0000_0145;
         22:      val = 32'h0000_00A2;
         23:      val = 32'h0000_0051;
         24:      val = 32'h0000_0028;
         25:      val = 32'h0000_0014;
         26:      val = 32'h0000_000A;
         27:      val = 32'h0000_0005;
         28:      val = 32'h0000_0002;
         29:      val = 32'h0000_0001;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- src/ar3d_if.sv -----
// ----------------------------------------------------------------------------
// ar3d_req_if / ar3d_rsp_if
// Valid/ready channels carrying the point and angle in, the rotated point out.
// ----------------------------------------------------------------------------
interface ar3d_req_if #(
   parameter int COORD_WIDTH = ar3d_pkg::DEF_COORD_WIDTH
);
   import ar3d_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [COORD_WIDTH-1:0]  in_x;
   logic signed [COORD_WIDTH-1:0]  in_y;
   logic signed [COORD_WIDTH-1:0]  in_z;
   logic        [ANGLE_WIDTH-1:0]  turn_angle;
   logic        [AXIS_WIDTH-1:0]   axis_select;

   modport source (output valid, in_x, in_y, in_z, turn_angle, axis_select,
                   input ready);
   modport sink   (input valid, in_x, in_y, in_z, turn_angle, axis_select,
                   output ready);
endinterface

interface ar3d_rsp_if #(
   parameter int COORD_WIDTH = ar3d_pkg::DEF_COORD_WIDTH
);
   logic                           valid;
   logic                           ready;
   logic signed [COORD_WIDTH-1:0]  out_x;
   logic signed [COORD_WIDTH-1:0]  out_y;
   logic signed [COORD_WIDTH-1:0]  out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

// ----- src/ar3d_prerot.sv -----
// ----------------------------------------------------------------------------
// ar3d_prerot
// Input stage: picks the coordinate pair, folds the angle into a half turn
// about zero and scales the pair up by the guard bits.
// ----------------------------------------------------------------------------
module ar3d_prerot #(
   parameter int COORD_WIDTH = ar3d_pkg::DEF_COORD_WIDTH,
   parameter int DATA_WIDTH  = ar3d_pkg::DEF_COORD_WIDTH + 11,
   parameter int SB_WIDTH    = 3 * ar3d_pkg::DEF_COORD_WIDTH + 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  logic signed [COORD_WIDTH-1:0]         in_x,
   input  logic signed [COORD_WIDTH-1:0]         in_y,
   input  logic signed [COORD_WIDTH-1:0]         in_z,
   input  logic [ar3d_pkg::ANGLE_WIDTH-1:0]      turn_angle,
   input  ar3d_pkg::axis_type                    axis_select,
   output logic                                  dn_valid,
   input  logic                                  dn_ready,
   output logic signed [DATA_WIDTH-1:0]          a_out,
   output logic signed [DATA_WIDTH-1:0]          b_out,
   output logic signed [ar3d_pkg::Z_WIDTH-1:0]   z_out,
   output logic [SB_WIDTH-1:0]                   sb_out
);
   import ar3d_pkg::*;

   logic                            valid_ff;
   logic signed [DATA_WIDTH-1:0]    a_ff, a_in;
   logic signed [DATA_WIDTH-1:0]    b_ff, b_in;
   logic signed [Z_WIDTH-1:0]       z_ff, z_in;
   logic [SB_WIDTH-1:0]             sb_ff, sb_in;
   logic signed [COORD_WIDTH-1:0]   sel_a, sel_b, sel_c;
   logic signed [DATA_WIDTH-1:0]    ext_a, ext_b;
   logic [ANGLE_WIDTH-1:0]          shifted;
   logic [ANGLE_WIDTH-1:0]          folded;
   logic                            flip;

   always_comb begin
      case (axis_select)
         AXIS_X: begin
            sel_a = in_y;
            sel_b = in_z;
            sel_c = in_x;
         end
         AXIS_Y: begin
            sel_a = in_z;
            sel_b = in_x;
            sel_c = in_y;
         end
         default: begin
            // Z rotation, and also the pass-through code, which keeps x, y, z order.
            sel_a = in_x;
            sel_b = in_y;
            sel_c = in_z;
         end
      endcase

      // Angles in the second and third quarter turn become a half-turn flip of
      // the pair followed by the remaining angle.
      shifted = turn_angle + QUARTER_TURN;
      flip    = shifted[ANGLE_WIDTH-1];
      folded  = flip ? (turn_angle - HALF_TURN) : turn_angle;

      ext_a = DATA_WIDTH'(sel_a) <<< GUARD_BITS;
      ext_b = DATA_WIDTH'(sel_b) <<< GUARD_BITS;
      a_in  = flip ? -ext_a : ext_a;
      b_in  = flip ? -ext_b : ext_b;
      z_in  = Z_WIDTH'($signed(folded));
      sb_in = {axis_select, sel_c, sel_a, sel_b};
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         z_ff  <= z_in;
         sb_ff <= sb_in;
      end
   end

   assign dn_valid = valid_ff;
   assign a_out    = a_ff;
   assign b_out    = b_ff;
   assign z_out    = z_ff;
   assign sb_out   = sb_ff;

endmodule

// ----- src/ar3d_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// ar3d_cordic_stage
// One registered micro-rotation of the rotation pipeline.
// ----------------------------------------------------------------------------
module ar3d_cordic_stage #(
   parameter int DATA_WIDTH = ar3d_pkg::DEF_COORD_WIDTH + 11,
   parameter int SB_WIDTH   = 3 * ar3d_pkg::DEF_COORD_WIDTH + 2,
   parameter int STAGE      = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  logic signed [DATA_WIDTH-1:0]          a_data,
   input  logic signed [DATA_WIDTH-1:0]          b_data,
   input  logic signed [ar3d_pkg::Z_WIDTH-1:0]   z_data,
   input  logic [SB_WIDTH-1:0]                   sb_data,
   output logic                                  dn_valid,
   input  logic                                  dn_ready,
   output logic signed [DATA_WIDTH-1:0]          a_out,
   output logic signed [DATA_WIDTH-1:0]          b_out,
   output logic signed [ar3d_pkg::Z_WIDTH-1:0]   z_out,
   output logic [SB_WIDTH-1:0]                   sb_out
);
   import ar3d_pkg::*;

   localparam logic signed [Z_WIDTH-1:0] STEP_ANGLE = Z_WIDTH'(atan_turns(STAGE));

   logic                          valid_ff;
   logic signed [DATA_WIDTH-1:0]  a_ff, a_in;
   logic signed [DATA_WIDTH-1:0]  b_ff, b_in;
   logic signed [Z_WIDTH-1:0]     z_ff, z_in;
   logic [SB_WIDTH-1:0]           sb_ff;
   logic signed [DATA_WIDTH-1:0]  da, db;

   always_comb begin
      da = b_data >>> STAGE;
      db = a_data >>> STAGE;
      // Turn towards zero residual angle.
      if (!z_data[Z_WIDTH-1]) begin
         a_in = a_data - da;
         b_in = b_data + db;
         z_in = z_data - STEP_ANGLE;
      end else begin
         a_in = a_data + da;
         b_in = b_data - db;
         z_in = z_data + STEP_ANGLE;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         z_ff  <= z_in;
         sb_ff <= sb_data;
      end
   end

   assign dn_valid = valid_ff;
   assign a_out    = a_ff;
   assign b_out    = b_ff;
   assign z_out    = z_ff;
   assign sb_out   = sb_ff;

endmodule

// ----- src/ar3d_scale.sv -----
// ----------------------------------------------------------------------------
// ar3d_scale
// Four-stage gain removal: magnitude, gain multiply, round away from zero,
// saturate and map the pair back onto x, y and z in the output register.
// ----------------------------------------------------------------------------
module ar3d_scale #(
   parameter int COORD_WIDTH = ar3d_pkg::DEF_COORD_WIDTH,
   parameter int DATA_WIDTH  = ar3d_pkg::DEF_COORD_WIDTH + 11,
   parameter int SB_WIDTH    = 3 * ar3d_pkg::DEF_COORD_WIDTH + 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           up_valid,
   output logic                           up_ready,
   input  logic signed [DATA_WIDTH-1:0]   a_data,
   input  logic signed [DATA_WIDTH-1:0]   b_data,
   input  logic [SB_WIDTH-1:0]            sb_data,
   output logic                           dn_valid,
   input  logic                           dn_ready,
   output logic signed [COORD_WIDTH-1:0]  out_x,
   output logic signed [COORD_WIDTH-1:0]  out_y,
   output logic signed [COORD_WIDTH-1:0]  out_z
);
   import ar3d_pkg::*;

   localparam int MAG_WIDTH = (DATA_WIDTH > GAIN_SHIFT + 1) ? DATA_WIDTH : GAIN_SHIFT + 1;
   localparam int HI_WIDTH  = MAG_WIDTH - GAIN_SHIFT;
   localparam int SUM_WIDTH = MAG_WIDTH + 1;
   localparam int RND_WIDTH = SUM_WIDTH - GUARD_BITS;
   localparam int PROD_LO_WIDTH = 2 * GAIN_SHIFT;
   localparam logic [SUM_WIDTH-1:0] ROUND_HALF = SUM_WIDTH'(1) << (GUARD_BITS - 1);
   localparam logic [RND_WIDTH-1:0] LIM_NEG    = RND_WIDTH'(1) << (COORD_WIDTH - 1);
   localparam logic [RND_WIDTH-1:0] LIM_POS    = LIM_NEG - RND_WIDTH'(1);

   // Stage handshake: valid per stage, ready rippling back from the output.
   logic [3:0]                   valid_ff;
   logic [4:0]                   stg_ready;

   logic [SB_WIDTH-1:0]          sb1_ff, sb2_ff, sb3_ff;
   logic [1:0]                   neg1_ff, neg2_ff, neg3_ff;
   logic [MAG_WIDTH-1:0]         mag_ff [0:1];
   logic [MAG_WIDTH-1:0]         mag_in [0:1];
   logic [MAG_WIDTH-1:0]         phi_ff [0:1];
   logic [MAG_WIDTH-1:0]         phi_in [0:1];
   logic [GAIN_SHIFT-1:0]        plo_ff [0:1];
   logic [GAIN_SHIFT-1:0]        plo_in [0:1];
   logic [RND_WIDTH-1:0]         rnd_ff [0:1];
   logic [RND_WIDTH-1:0]         rnd_in [0:1];
   logic [DATA_WIDTH-1:0]        abs_val [0:1];
   logic [HI_WIDTH-1:0]          hi_part [0:1];
   logic [PROD_LO_WIDTH-1:0]     lo_prod [0:1];
   logic [SUM_WIDTH-1:0]         sum_val [0:1];
   logic [RND_WIDTH-1:0]         sat_mag [0:1];
   logic signed [COORD_WIDTH-1:0] res [0:1];
   logic [1:0]                   neg_in;

   logic signed [COORD_WIDTH-1:0] x_ff, x_in;
   logic signed [COORD_WIDTH-1:0] y_ff, y_in;
   logic signed [COORD_WIDTH-1:0] z_ff, z_in;
   axis_type                      axis_sb;
   logic signed [COORD_WIDTH-1:0] c_sb, oa_sb, ob_sb;

   always_comb begin
      stg_ready[4] = dn_ready;
      for (int k = 3; k >= 0; k--) begin
         stg_ready[k] = !valid_ff[k] || stg_ready[k+1];
      end
   end

   assign up_ready = stg_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stg_ready[0]) valid_ff[0] <= up_valid;
         if (stg_ready[1]) valid_ff[1] <= valid_ff[0];
         if (stg_ready[2]) valid_ff[2] <= valid_ff[1];
         if (stg_ready[3]) valid_ff[3] <= valid_ff[2];
      end
   end

   always_comb begin
      neg_in = {b_data[DATA_WIDTH-1], a_data[DATA_WIDTH-1]};
      abs_val[0] = neg_in[0] ? (~a_data + 1'b1) : a_data;
      abs_val[1] = neg_in[1] ? (~b_data + 1'b1) : b_data;
      for (int l = 0; l < 2; l++) begin
         mag_in[l]  = MAG_WIDTH'(abs_val[l]);
         // The gain is applied to the upper and lower parts of the magnitude.
         hi_part[l] = mag_ff[l][MAG_WIDTH-1:GAIN_SHIFT];
         phi_in[l]  = MAG_WIDTH'(hi_part[l] * GAIN_Q31);
         lo_prod[l] = mag_ff[l][GAIN_SHIFT-1:0] * GAIN_Q31;
         plo_in[l]  = lo_prod[l][PROD_LO_WIDTH-1:GAIN_SHIFT];
         sum_val[l] = {1'b0, phi_ff[l]} + SUM_WIDTH'(plo_ff[l]) + ROUND_HALF;
         rnd_in[l]  = sum_val[l][SUM_WIDTH-1:GUARD_BITS];
         if (neg3_ff[l]) begin
            sat_mag[l] = (rnd_ff[l] > LIM_NEG) ? LIM_NEG : rnd_ff[l];
            res[l]     = COORD_WIDTH'(-sat_mag[l]);
         end else begin
            sat_mag[l] = (rnd_ff[l] > LIM_POS) ? LIM_POS : rnd_ff[l];
            res[l]     = COORD_WIDTH'(sat_mag[l]);
         end
      end
   end

   assign {axis_sb, c_sb, oa_sb, ob_sb} = sb3_ff;

   always_comb begin
      case (axis_sb)
         AXIS_X: begin
            x_in = c_sb;
            y_in = res[0];
            z_in = res[1];
         end
         AXIS_Y: begin
            x_in = res[1];
            y_in = c_sb;
            z_in = res[0];
         end
         AXIS_Z: begin
            x_in = res[0];
            y_in = res[1];
            z_in = c_sb;
         end
         default: begin
            // No rotation: the original point is carried alongside.
            x_in = oa_sb;
            y_in = ob_sb;
            z_in = c_sb;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stg_ready[0] && up_valid) begin
         mag_ff  <= mag_in;
         neg1_ff <= neg_in;
         sb1_ff  <= sb_data;
      end
      if (stg_ready[1] && valid_ff[0]) begin
         phi_ff  <= phi_in;
         plo_ff  <= plo_in;
         neg2_ff <= neg1_ff;
         sb2_ff  <= sb1_ff;
      end
      if (stg_ready[2] && valid_ff[1]) begin
         rnd_ff  <= rnd_in;
         neg3_ff <= neg2_ff;
         sb3_ff  <= sb2_ff;
      end
      if (stg_ready[3] && valid_ff[2]) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dn_valid = valid_ff[3];
   assign out_x    = x_ff;
   assign out_y    = y_ff;
   assign out_z    = z_ff;

endmodule

// ----- src/axis_rotation_3d_core.sv -----
// ----------------------------------------------------------------------------
// axis_rotation_3d_core
// Rotates a signed Q16.16 point about the X, Y or Z axis by a binary angle.
// ----------------------------------------------------------------------------
// Usage:
// A point (in_x, in_y, in_z), a binary angle turn_angle (2^32 is a full turn)
// and axis_select (0 X, 1 Y, 2 Z) arrive on the req_port channel; each
// transfer yields exactly one rotated point on the rsp_port channel. The
// coordinate on the chosen axis passes through, the other two are rotated
// and saturated to the coordinate range. Axis code 3 returns the point as is.
// A request transfer reaches response valid through one input stage, one
// registered micro-rotation per stage, and four gain-removal stages. A new
// point is taken in every cycle while the receiver accepts responses. Each
// stage holds its own valid bit and its ready is derived from the stage
// after it, so when the receiver stalls the pipeline compacts its bubbles
// and keeps accepting until every stage is full.
// Synchronous reset empties the pipeline; the block holds no other state.
// ----------------------------------------------------------------------------
module axis_rotation_3d_core #(
   parameter int COORD_WIDTH     = ar3d_pkg::DEF_COORD_WIDTH,
   parameter int ROTATION_STAGES = ar3d_pkg::DEF_ROTATION_STAGES
) (
   input  logic          clock,
   input  logic          reset,
   ar3d_req_if.sink      req_port,
   ar3d_rsp_if.source    rsp_port
);
   import ar3d_pkg::*;

   // Guard bits plus headroom for the half-turn negation and the CORDIC gain.
   localparam int DATA_WIDTH = COORD_WIDTH + GUARD_BITS + 3;
   localparam int SB_WIDTH   = 3 * COORD_WIDTH + AXIS_WIDTH;
   localparam int N          = ROTATION_STAGES;

   logic                          stg_valid [0:N];
   logic                          stg_ready [0:N];
   logic signed [DATA_WIDTH-1:0]  stg_a     [0:N];
   logic signed [DATA_WIDTH-1:0]  stg_b     [0:N];
   logic signed [Z_WIDTH-1:0]     stg_z     [0:N];
   logic [SB_WIDTH-1:0]           stg_sb    [0:N];

   ar3d_prerot #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_WIDTH  (DATA_WIDTH),
      .SB_WIDTH    (SB_WIDTH)
   ) u_prerot (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (req_port.valid),
      .up_ready    (req_port.ready),
      .in_x        (req_port.in_x),
      .in_y        (req_port.in_y),
      .in_z        (req_port.in_z),
      .turn_angle  (req_port.turn_angle),
      .axis_select (req_port.axis_select),
      .dn_valid    (stg_valid[0]),
      .dn_ready    (stg_ready[0]),
      .a_out       (stg_a[0]),
      .b_out       (stg_b[0]),
      .z_out       (stg_z[0]),
      .sb_out      (stg_sb[0])
   );

   for (genvar k = 0; k < N; k++) begin : g_rot
      ar3d_cordic_stage #(
         .DATA_WIDTH (DATA_WIDTH),
         .SB_WIDTH   (SB_WIDTH),
         .STAGE      (k)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[k]),
         .up_ready (stg_ready[k]),
         .a_data   (stg_a[k]),
         .b_data   (stg_b[k]),
         .z_data   (stg_z[k]),
         .sb_data  (stg_sb[k]),
         .dn_valid (stg_valid[k+1]),
         .dn_ready (stg_ready[k+1]),
         .a_out    (stg_a[k+1]),
         .b_out    (stg_b[k+1]),
         .z_out    (stg_z[k+1]),
         .sb_out   (stg_sb[k+1])
      );
   end

   // The residual angle of the last stage is not needed further on.
   ar3d_scale #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_WIDTH  (DATA_WIDTH),
      .SB_WIDTH    (SB_WIDTH)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .up_valid (stg_valid[N]),
      .up_ready (stg_ready[N]),
      .a_data   (stg_a[N]),
      .b_data   (stg_b[N]),
      .sb_data  (stg_sb[N]),
      .dn_valid (rsp_port.valid),
      .dn_ready (rsp_port.ready),
      .out_x    (rsp_port.out_x),
      .out_y    (rsp_port.out_y),
      .out_z    (rsp_port.out_z)
   );

endmodule

// ----- src/ar3d_checker.sv -----
// ----------------------------------------------------------------------------
// ar3d_checker
// Port-level checks of the rotation core: occupancy, stalls and reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ar3d_checker #(
   parameter int COORD_WIDTH     = ar3d_pkg::DEF_COORD_WIDTH,
   parameter int ROTATION_STAGES = ar3d_pkg::DEF_ROTATION_STAGES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [COORD_WIDTH-1:0] rsp_x,
   input  logic signed [COORD_WIDTH-1:0] rsp_y,
   input  logic signed [COORD_WIDTH-1:0] rsp_z
);
   import ar3d_pkg::*;

   // Input stage, one stage per micro-rotation, four scaling stages.
   localparam int DEPTH     = ROTATION_STAGES + 5;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (req_xfer && !rsp_xfer) begin
         count_in = count_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `AR3D_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `AR3D_ASSERT(a_no_phantom, clock, reset, rsp_valid |-> count_ff != '0)
   `AR3D_ASSERT(a_backpressure_full, clock, reset, !req_ready |-> count_ff == CNT_WIDTH'(DEPTH))
   `AR3D_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x) && $stable(rsp_y) && $stable(rsp_z))

endmodule

bind axis_rotation_3d_core ar3d_checker #(
   .COORD_WIDTH     (COORD_WIDTH),
   .ROTATION_STAGES (ROTATION_STAGES)
) u_ar3d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_x     (rsp_port.out_x),
   .rsp_y     (rsp_port.out_y),
   .rsp_z     (rsp_port.out_z)
);
